>>> hdl/rgbhsv_pkg.sv
// shared constants and types for the rgb to hsv pixel core
package rgbhsv_pkg;

    localparam int CHANNEL_BITS_DEF = 8;
    localparam int Q_BITS = 16;
    localparam int DIV_LANES = 2;
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } sector_t;

endpackage

>>> hdl/rgbhsv_divider.sv
// two-lane pipelined restoring divider, one quotient bit per stage, fractional quotient
module rgbhsv_divider #(
    parameter int REM_BITS  = rgbhsv_pkg::CHANNEL_BITS_DEF + 3,
    parameter int SIDE_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF + 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [REM_BITS-1:0]              in_rem [rgbhsv_pkg::DIV_LANES],
    input  logic [REM_BITS-1:0]              in_den [rgbhsv_pkg::DIV_LANES],
    input  logic [SIDE_BITS-1:0]             in_side,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [rgbhsv_pkg::Q_BITS-1:0]    out_quo [rgbhsv_pkg::DIV_LANES],
    output logic [SIDE_BITS-1:0]             out_side
);
    import rgbhsv_pkg::*;

    logic [Q_BITS-1:0]    valid_reg;
    logic [Q_BITS:0]      stage_rdy;
    logic [REM_BITS-1:0]  rem_reg  [Q_BITS-1][DIV_LANES];
    logic [REM_BITS-1:0]  den_reg  [Q_BITS-1][DIV_LANES];
    logic [Q_BITS-1:0]    quo_reg  [Q_BITS][DIV_LANES];
    logic [SIDE_BITS-1:0] side_reg [Q_BITS];

    assign stage_rdy[Q_BITS] = out_ready;
    assign in_ready          = stage_rdy[0];

    for (genvar s = 0; s < Q_BITS; s++)
    begin : g_stage
        logic                 valid_src;
        logic [REM_BITS-1:0]  rem_src  [DIV_LANES];
        logic [REM_BITS-1:0]  den_src  [DIV_LANES];
        logic [Q_BITS-1:0]    quo_src  [DIV_LANES];
        logic [SIDE_BITS-1:0] side_src;
        logic [REM_BITS-1:0]  rem_next [DIV_LANES];
        logic [Q_BITS-1:0]    quo_next [DIV_LANES];

        if (s == 0)
        begin : g_first
            always_comb
            begin
                valid_src = in_valid;
                side_src  = in_side;
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_src[l] = in_rem[l];
                    den_src[l] = in_den[l];
                    quo_src[l] = '0;
                end
            end
        end
        else
        begin : g_later
            always_comb
            begin
                valid_src = valid_reg[s-1];
                side_src  = side_reg[s-1];
                for (int l = 0; l < DIV_LANES; l++)
                begin
                    rem_src[l] = rem_reg[s-1][l];
                    den_src[l] = den_reg[s-1][l];
                    quo_src[l] = quo_reg[s-1][l];
                end
            end
        end

        // one restoring step per lane
        always_comb
        begin
            logic [REM_BITS:0] rem2;
            logic [REM_BITS:0] sub;
            logic              take;
            for (int l = 0; l < DIV_LANES; l++)
            begin
                rem2        = {rem_src[l], 1'b0};
                sub         = rem2 - {1'b0, den_src[l]};
                take        = rem2 >= {1'b0, den_src[l]};
                rem_next[l] = take ? sub[REM_BITS-1:0] : rem2[REM_BITS-1:0];
                quo_next[l] = {quo_src[l][Q_BITS-2:0], take};
            end
        end

        assign stage_rdy[s] = !valid_reg[s] || stage_rdy[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (stage_rdy[s])
                valid_reg[s] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            if (stage_rdy[s] && valid_src)
            begin
                side_reg[s] <= side_src;
                for (int l = 0; l < DIV_LANES; l++)
                    quo_reg[s][l] <= quo_next[l];
            end
        end

        if (s < Q_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (stage_rdy[s] && valid_src)
                begin
                    for (int l = 0; l < DIV_LANES; l++)
                    begin
                        rem_reg[s][l] <= rem_next[l];
                        den_reg[s][l] <= den_src[l];
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[Q_BITS-1];
    assign out_side  = side_reg[Q_BITS-1];
    always_comb
    begin
        for (int l = 0; l < DIV_LANES; l++)
            out_quo[l] = quo_reg[Q_BITS-1][l];
    end

endmodule

>>> hdl/rgb_to_hsv_pixel_core.sv
// rgb to hsv pixel converter, fully pipelined, one pixel per clock while the output is not stalled
//
//  channel  | handshake                 | beat fields
//  ---------+---------------------------+-------------------------------
//  pixel    | pixel_valid / pixel_ready | red, green, blue
//  hsv      | hsv_valid / hsv_ready     | hue, saturation, brightness
//
// three front stages (max/min, spread, sector numerator) then a 16-stage divider,
// one quotient bit per stage for hue and saturation side by side. a new beat is
// taken every cycle while the output is not stalled.
// every stage holds while its successor is full and stalled; empty stages
// keep filling, so stalls lose and repeat nothing.
// reset clears only the stage valid bits.
module rgb_to_hsv_pixel_core #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          pixel_valid,
    output logic                          pixel_ready,
    input  logic [CHANNEL_BITS-1:0]       red,
    input  logic [CHANNEL_BITS-1:0]       green,
    input  logic [CHANNEL_BITS-1:0]       blue,
    output logic                          hsv_valid,
    input  logic                          hsv_ready,
    output logic [rgbhsv_pkg::Q_BITS-1:0] hue,
    output logic [rgbhsv_pkg::Q_BITS-1:0] saturation,
    output logic [CHANNEL_BITS-1:0]       brightness
);
    import rgbhsv_pkg::*;

    localparam int CB        = CHANNEL_BITS;
    localparam int DIFF_BITS = CB + 1;
    localparam int REM_BITS  = CB + 3;
    localparam int NUM_BITS  = CB + 4;
    localparam int SIDE_BITS = CB + 1;

    // stage 1: max, min, sector, cross difference
    logic                        red_top;
    logic                        red_low;
    sector_t                     sector_next;
    logic [CB-1:0]               max_next;
    logic [CB-1:0]               min_next;
    logic signed [DIFF_BITS-1:0] diff_next;

    logic                        s1_valid_reg;
    logic [CB-1:0]               s1_max_reg;
    logic [CB-1:0]               s1_min_reg;
    sector_t                     s1_sector_reg;
    logic signed [DIFF_BITS-1:0] s1_diff_reg;

    logic                        s2_valid_reg;
    logic [CB-1:0]               s2_max_reg;
    logic [CB-1:0]               s2_delta_reg;
    sector_t                     s2_sector_reg;
    logic signed [DIFF_BITS-1:0] s2_diff_reg;

    logic signed [NUM_BITS-1:0]  offset_d;
    logic signed [NUM_BITS-1:0]  num_next;
    logic [REM_BITS-1:0]         six_next;

    logic                        s3_valid_reg;
    logic signed [NUM_BITS-1:0]  s3_num_reg;
    logic [REM_BITS-1:0]         s3_six_reg;
    logic [CB-1:0]               s3_delta_reg;
    logic [CB-1:0]               s3_max_reg;

    logic                        s1_rdy;
    logic                        s2_rdy;
    logic                        s3_rdy;

    logic signed [NUM_BITS-1:0]  num_wrap;
    logic                        delta_zero;
    logic                        max_zero;
    logic                        sat_full;

    logic                        div_in_ready;
    logic [REM_BITS-1:0]         div_rem [DIV_LANES];
    logic [REM_BITS-1:0]         div_den [DIV_LANES];
    logic [SIDE_BITS-1:0]        div_side;
    logic [Q_BITS-1:0]           div_quo [DIV_LANES];
    logic [SIDE_BITS-1:0]        out_side;

    assign s3_rdy      = !s3_valid_reg || div_in_ready;
    assign s2_rdy      = !s2_valid_reg || s3_rdy;
    assign s1_rdy      = !s1_valid_reg || s2_rdy;
    assign pixel_ready = s1_rdy;

    // ties go to red, then green
    assign red_top = (red >= green) && (red >= blue);
    assign red_low = (red <= green) && (red <= blue);

    always_comb
    begin
        priority if (red_top)
        begin
            sector_next = SECT_RED;
            max_next    = red;
            diff_next   = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green >= blue)
        begin
            sector_next = SECT_GREEN;
            max_next    = green;
            diff_next   = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sector_next = SECT_BLUE;
            max_next    = blue;
            diff_next   = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_comb
    begin
        priority if (red_low)
            min_next = red;
        else if (green <= blue)
            min_next = green;
        else
            min_next = blue;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
                s1_valid_reg <= pixel_valid;
            if (s2_rdy)
                s2_valid_reg <= s1_valid_reg;
            if (s3_rdy)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && pixel_valid)
        begin
            s1_max_reg    <= max_next;
            s1_min_reg    <= min_next;
            s1_sector_reg <= sector_next;
            s1_diff_reg   <= diff_next;
        end
    end

    // stage 2: spread
    always_ff @(posedge clk)
    begin
        if (s2_rdy && s1_valid_reg)
        begin
            s2_max_reg    <= s1_max_reg;
            s2_delta_reg  <= s1_max_reg - s1_min_reg;
            s2_sector_reg <= s1_sector_reg;
            s2_diff_reg   <= s1_diff_reg;
        end
    end

    // stage 3: sector numerator and six times the spread
    always_comb
    begin
        unique case (s2_sector_reg)
            SECT_RED:   offset_d = '0;
            SECT_GREEN: offset_d = $signed(NUM_BITS'(s2_delta_reg) << 1);
            SECT_BLUE:  offset_d = $signed(NUM_BITS'(s2_delta_reg) << 2);
            default:    offset_d = '0;
        endcase
        num_next = offset_d + NUM_BITS'(s2_diff_reg);
        six_next = (REM_BITS'(s2_delta_reg) << 2) + (REM_BITS'(s2_delta_reg) << 1);
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && s2_valid_reg)
        begin
            s3_num_reg   <= num_next;
            s3_six_reg   <= six_next;
            s3_delta_reg <= s2_delta_reg;
            s3_max_reg   <= s2_max_reg;
        end
    end

    // wrap negative hue, route special cases to a zero quotient
    assign num_wrap   = s3_num_reg[NUM_BITS-1] ?
                        s3_num_reg + $signed({1'b0, s3_six_reg}) : s3_num_reg;
    assign delta_zero = (s3_delta_reg == '0);
    assign max_zero   = (s3_max_reg == '0);
    assign sat_full   = !max_zero && (s3_delta_reg == s3_max_reg);

    always_comb
    begin
        div_rem[LANE_HUE] = delta_zero ? '0 : num_wrap[REM_BITS-1:0];
        div_den[LANE_HUE] = delta_zero ? REM_BITS'(1) : s3_six_reg;
        div_rem[LANE_SAT] = (max_zero || sat_full) ? '0 : REM_BITS'(s3_delta_reg);
        div_den[LANE_SAT] = (max_zero || sat_full) ? REM_BITS'(1) : REM_BITS'(s3_max_reg);
        div_side          = {sat_full, s3_max_reg};
    end

    rgbhsv_divider #(
        .REM_BITS  (REM_BITS),
        .SIDE_BITS (SIDE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_ready  (div_in_ready),
        .in_rem    (div_rem),
        .in_den    (div_den),
        .in_side   (div_side),
        .out_valid (hsv_valid),
        .out_ready (hsv_ready),
        .out_quo   (div_quo),
        .out_side  (out_side)
    );

    assign hue        = div_quo[LANE_HUE];
    assign saturation = div_quo[LANE_SAT] | {Q_BITS{out_side[CB]}};
    assign brightness = out_side[CB-1:0];

endmodule

>>> hdl/rgbhsv_checker.sv
// port checker for the rgb to hsv pixel core, bound to the top level
module rgbhsv_checker #(
    parameter int CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          pixel_valid,
    input logic                          pixel_ready,
    input logic [CHANNEL_BITS-1:0]       red,
    input logic [CHANNEL_BITS-1:0]       green,
    input logic [CHANNEL_BITS-1:0]       blue,
    input logic                          hsv_valid,
    input logic                          hsv_ready,
    input logic [rgbhsv_pkg::Q_BITS-1:0] hue,
    input logic [rgbhsv_pkg::Q_BITS-1:0] saturation,
    input logic [CHANNEL_BITS-1:0]       brightness
);
    import rgbhsv_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && !hsv_ready |=> hsv_valid && $stable(hue) && $stable(saturation)
            && $stable(brightness))
        else $error("hsv beat changed while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !hsv_valid)
        else $error("result valid straight out of reset");

    // black pixel has no saturation and no hue
    a_black: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (brightness == '0) |-> (saturation == '0) && (hue == '0))
        else $error("black pixel with nonzero saturation or hue");

    // gray pixel has no hue
    a_gray: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (saturation == '0) |-> (hue == '0))
        else $error("unsaturated pixel with nonzero hue");

endmodule

bind rgb_to_hsv_pixel_core rgbhsv_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_checker (.*);

>>> sim/tb_rgb_to_hsv_pixel_core.sv
// testbench for the rgb to hsv pixel core: directed pixel table, then random checked pixels
module tb_rgb_to_hsv_pixel_core;

    import rgbhsv_pkg::*;

    localparam int CB = CHANNEL_BITS_DEF;
    localparam int QB = Q_BITS;
    localparam int ONE_Q = 1 << QB;
    localparam int MAX_Q = ONE_Q - 1;
    localparam int TOP_CH = (1 << CB) - 1;
    localparam int PIPE_DEPTH = 19;
    localparam int RANDOM_PIXELS = 1200;

    typedef struct packed {
        logic [QB-1:0] hue;
        logic [QB-1:0] sat;
        logic [CB-1:0] val;
    } hsv_t;

    typedef struct packed {
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        logic          has_exp;
        hsv_t          exp;
    } pixel_row_t;

    localparam int N_ROWS = 25;

    pixel_row_t directed_rows [N_ROWS] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd0,     8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{16'd0,     16'd0,     8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{16'd0,     16'd0,     8'd128}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{16'd21845, 16'd65535, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{16'd43690, 16'd65535, 8'd255}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{16'd10922, 16'd65535, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{16'd32768, 16'd65535, 8'd255}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{16'd54613, 16'd65535, 8'd255}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{16'd0,     16'd65535, 8'd1}},
        '{8'd1,   8'd1,   8'd0,   1'b1, '{16'd10922, 16'd65535, 8'd1}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{16'd0,     16'd0,     8'd1}},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0},
        '{8'd200, 8'd100, 8'd150, 1'b0, '0},
        '{8'd100, 8'd200, 8'd150, 1'b0, '0},
        '{8'd150, 8'd100, 8'd200, 1'b0, '0},
        '{8'd1,   8'd2,   8'd3,   1'b0, '0},
        '{8'd170, 8'd85,  8'd170, 1'b0, '0},
        '{8'd85,  8'd170, 8'd85,  1'b0, '0},
        '{8'd254, 8'd0,   8'd1,   1'b0, '0},
        '{8'd0,   8'd1,   8'd254, 1'b0, '0},
        '{8'd127, 8'd128, 8'd129, 1'b0, '0},
        '{8'd255, 8'd255, 8'd254, 1'b0, '0},
        '{8'd128, 8'd127, 8'd127, 1'b0, '0}
    };

    logic          clk;
    logic          rst_n;
    logic          pixel_valid;
    logic          pixel_ready;
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    logic          hsv_valid;
    logic          hsv_ready;
    logic [QB-1:0] hue;
    logic [QB-1:0] saturation;
    logic [CB-1:0] brightness;

    hsv_t hsv_expected [$];
    int   mismatch_count = 0;
    bit   fill_burst = 0;
    bit   hold_off_req = 0;
    bit   steady_flow = 0;

    rgb_to_hsv_pixel_core #(
        .CHANNEL_BITS(CB)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .hsv_valid  (hsv_valid),
        .hsv_ready  (hsv_ready),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic hsv_t predict_hsv(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                         input logic [CB-1:0] b);
        logic [CB-1:0] top;
        logic [CB-1:0] low;
        sector_t       sect;
        int            spread;
        int            num;
        int            q;
        hsv_t          res;
        top = r;
        sect = SECT_RED;
        if (g > top)
        begin
            top = g;
            sect = SECT_GREEN;
        end
        if (b > top)
        begin
            top = b;
            sect = SECT_BLUE;
        end
        low = r;
        if (g < low)
            low = g;
        if (b < low)
            low = b;
        spread = int'(top) - int'(low);
        res.val = top;
        res.sat = '0;
        res.hue = '0;
        if (top != 0)
        begin
            q = (spread * ONE_Q) / int'(top);
            res.sat = (q > MAX_Q) ? QB'(MAX_Q) : QB'(q);
        end
        if (spread != 0)
        begin
            case (sect)
                SECT_RED:   num = int'(g) - int'(b);
                SECT_GREEN: num = 2 * spread + int'(b) - int'(r);
                default:    num = 4 * spread + int'(r) - int'(g);
            endcase
            if (num < 0)
                num += 6 * spread;
            q = (num * ONE_Q) / (6 * spread);
            res.hue = (q > MAX_Q) ? QB'(MAX_Q) : QB'(q);
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // hold valid and payload until the beat is taken
    task automatic send_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                              input logic [CB-1:0] b, input hsv_t exp);
        int gap;
        gap = fill_burst ? 0 : pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pixel_valid <= 1'b1;
        red <= r;
        green <= g;
        blue <= b;
        @(posedge clk);
        while (!pixel_ready)
            @(posedge clk);
        hsv_expected.push_back(exp);
    endtask

    initial
    begin
        int stall;
        int run;
        hsv_ready = 1'b0;
        forever
        begin
            stall = pick_gap();
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
            if (steady_flow)
                stall = 0;
            if (hold_off_req)
            begin
                hold_off_req = 0;
                stall = 120;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                hsv_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            hsv_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        hsv_t want;
        if (rst_n && hsv_valid && hsv_ready)
        begin
            if (hsv_expected.size() == 0)
                report_mismatch($sformatf("unexpected hsv beat hue=%0d sat=%0d val=%0d",
                                          hue, saturation, brightness));
            else
            begin
                want = hsv_expected.pop_front();
                if (hue !== want.hue)
                    report_mismatch($sformatf("hue got %0d want %0d", hue, want.hue));
                if (saturation !== want.sat)
                    report_mismatch($sformatf("saturation got %0d want %0d",
                                              saturation, want.sat));
                if (brightness !== want.val)
                    report_mismatch($sformatf("brightness got %0d want %0d",
                                              brightness, want.val));
            end
        end
    end

    initial
    begin
        logic [CB-1:0] r;
        logic [CB-1:0] g;
        logic [CB-1:0] b;
        int            kind;
        rst_n = 1'b0;
        pixel_valid = 1'b0;
        red = '0;
        green = '0;
        blue = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                       directed_rows[i].has_exp ? directed_rows[i].exp
                       : predict_hsv(directed_rows[i].r, directed_rows[i].g,
                                     directed_rows[i].b));
        end

        for (int n = 0; n < RANDOM_PIXELS; n++)
        begin
            if (n == 400)
            begin
                fill_burst = 1;
                hold_off_req = 1;
            end
            if (n == 560 || n == 950)
                fill_burst = 0;
            if (n == 820)
            begin
                fill_burst = 1;
                steady_flow = 1;
            end
            if (n == 950)
                steady_flow = 0;
            r = CB'($urandom);
            g = CB'($urandom);
            b = CB'($urandom);
            kind = $urandom_range(0, 9);
            case (kind)
                0:
                begin
                    g = r;
                    b = r;
                end
                1:
                begin
                    case ($urandom_range(0, 2))
                        0: g = r;
                        1: b = g;
                        default: b = r;
                    endcase
                end
                2:
                begin
                    r = $urandom_range(0, 1) ? CB'(TOP_CH) : '0;
                    g = $urandom_range(0, 1) ? CB'(TOP_CH) : '0;
                end
                3:
                begin
                    r = CB'($urandom_range(0, 3));
                    g = CB'($urandom_range(0, 3));
                    b = CB'($urandom_range(0, 3));
                end
                4:
                begin
                    r = CB'(TOP_CH) - CB'($urandom_range(0, 2));
                    g = CB'(TOP_CH) - CB'($urandom_range(0, 2));
                end
                default:
                begin
                end
            endcase
            send_pixel(r, g, b, predict_hsv(r, g, b));
        end
        @(negedge clk);
        pixel_valid <= 1'b0;

        while (hsv_expected.size() != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        if (mismatch_count == 0)
            $display("rgb_to_hsv_pixel_core test passed");
        else
            $display("rgb_to_hsv_pixel_core test failed");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("rgb_to_hsv_pixel_core test failed");
        $finish;
    end

endmodule

>>> filelist.f
hdl/rgbhsv_pkg.sv
hdl/rgbhsv_divider.sv
hdl/rgb_to_hsv_pixel_core.sv
hdl/rgbhsv_checker.sv
sim/tb_rgb_to_hsv_pixel_core.sv
